// ===== rtl/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the periodic timer bank: opcodes, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 8;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned TIME_W         = 64;
  localparam int unsigned ID_W           = 8;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned MASK_W         = 8;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned PHASE_W        = 10;

  localparam logic [DATA_W-1:0]  FREQ_RESET   = 32'd100000000;
  localparam logic [PHASE_W-1:0] PHASE_LAST   = 10'd999;
  localparam logic [TIME_W-1:0]  UPTIME_STEP  = 64'd1000;
  localparam logic [CNT_W-1:0]   COUNT_SAT    = 4'd15;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_RESTART   = 3'd3,
    OP_SET_RATE  = 3'd4,
    OP_CLEAR_ALL = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic latch;
    logic inc_tick;
    logic fire;
    logic apply;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/periodic_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timer channels driven by a system tick, with start, stop,
// restart, set rate and clear all commands.
// ----------------------------------------------------------------------------
// One beat is handled at a time. A tick passes the execute, fire and emit
// states; start, stop, restart, clear all and rejected requests pass execute
// and emit. A valid set rate waits in the divide state for its reload value,
// which a bit-serial divider forms at one quotient bit per cycle. A finished
// result sits in its own register, so the next beat is taken while the result
// waits. The configuration port is always ready; write it only while idle.
module periodic_timer_bank import ptb_pkg::*; #(
  parameter int unsigned NumTimers = NUM_TIMERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DATA_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [ID_W-1:0]   timer_id_i,
  input  logic [DATA_W-1:0] rate_hz_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MASK_W-1:0] fire_mask_o,
  output logic [TIME_W-1:0] tick_count_o,
  output logic [TIME_W-1:0] uptime_ms_o,
  output logic [MASK_W-1:0] active_mask_o,
  output logic [CNT_W-1:0]  active_count_o,
  output logic [DATA_W-1:0] selected_reload_o,
  output logic              request_error_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptb_dp #(
    .NumTimers (NumTimers)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (opcode_i),
    .timer_id_i        (timer_id_i),
    .rate_hz_i         (rate_hz_i),
    .cfg_we_i          (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fire_mask_o       (fire_mask_o),
    .tick_count_o      (tick_count_o),
    .uptime_ms_o       (uptime_ms_o),
    .active_mask_o     (active_mask_o),
    .active_count_o    (active_count_o),
    .selected_reload_o (selected_reload_o),
    .request_error_o   (request_error_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in flight");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised without a beat in flight");

  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (NumTimers > MASK_W) ||
                    (32'(active_count_o) == $countones(active_mask_o)))
    else $error("active count disagrees with active mask");

endmodule

// ===== rtl/ptb_div.sv =====
// ----------------------------------------------------------------------------
// ptb_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptb_div import ptb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DATA_W);
  localparam logic [StepW-1:0] StepLast = StepW'(DATA_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dvs_q;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == StepLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/ptb_dp.sv =====
// ----------------------------------------------------------------------------
// ptb_dp
// Datapath: item and counter registers, channel lanes, reload divider and
// the result register.
// ----------------------------------------------------------------------------
module ptb_dp import ptb_pkg::*; #(
  parameter int unsigned NumTimers = NUM_TIMERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [ID_W-1:0]   timer_id_i,
  input  logic [DATA_W-1:0] rate_hz_i,
  input  logic              cfg_we_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MASK_W-1:0] fire_mask_o,
  output logic [TIME_W-1:0] tick_count_o,
  output logic [TIME_W-1:0] uptime_ms_o,
  output logic [MASK_W-1:0] active_mask_o,
  output logic [CNT_W-1:0]  active_count_o,
  output logic [DATA_W-1:0] selected_reload_o,
  output logic              request_error_o
);

  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned PadW = (NumTimers > MASK_W) ? NumTimers : MASK_W;
  localparam int unsigned PopW = ($clog2(NumTimers + 1) > CNT_W) ? $clog2(NumTimers + 1)
                                                                 : CNT_W;

  op_e                     op_q;
  logic [ID_W-1:0]         id_q;
  logic [DATA_W-1:0]       rate_q;
  logic [DATA_W-1:0]       freq_q;
  logic [TIME_W-1:0]       tick_q, tick_d;
  logic [TIME_W-1:0]       uptime_q, uptime_d;
  logic [PHASE_W-1:0]      phase_q, phase_d;
  logic [NumTimers-1:0]    active_q, active_d;
  logic [NumTimers-1:0]    fire_q, fire_d;
  logic [TIME_W-1:0]       deadline_q [NumTimers];
  logic [TIME_W-1:0]       deadline_d [NumTimers];
  logic [DATA_W-1:0]       reload_q [NumTimers];
  logic [DATA_W-1:0]       reload_d [NumTimers];
  logic                    out_valid_q;
  logic [MASK_W-1:0]       fire_mask_q;
  logic [TIME_W-1:0]       tick_count_q;
  logic [TIME_W-1:0]       uptime_ms_q;
  logic [MASK_W-1:0]       active_mask_q;
  logic [CNT_W-1:0]        active_count_q;
  logic [DATA_W-1:0]       selected_reload_q;
  logic                    request_error_q;

  logic                    id_ok;
  logic [IdxW-1:0]         idx;
  logic                    err;
  logic                    div_done;
  logic [DATA_W-1:0]       quotient;
  logic [PadW-1:0]         fire_pad;
  logic [PadW-1:0]         active_pad;
  logic [PopW-1:0]         pop;
  logic [CNT_W-1:0]        count_sat;
  logic [DATA_W-1:0]       sel_reload;

  assign id_ok = 32'(id_q) < 32'(NumTimers);
  assign idx   = id_q[IdxW-1:0];

  always_comb begin
    case (op_q)
      OP_START, OP_STOP, OP_RESTART: err = !id_ok;
      OP_SET_RATE:                   err = !id_ok || (rate_q == '0);
      default:                       err = 1'b0;
    endcase
  end

  ptb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (freq_q),
    .divisor_i  (rate_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign sts_o.is_tick  = (op_q == OP_TICK);
  assign sts_o.need_div = (op_q == OP_SET_RATE) && !err;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    tick_d     = tick_q;
    uptime_d   = uptime_q;
    phase_d    = phase_q;
    active_d   = active_q;
    fire_d     = fire_q;
    deadline_d = deadline_q;
    reload_d   = reload_q;

    if (cmd_i.latch) begin
      fire_d = '0;
    end

    if (cmd_i.inc_tick) begin
      tick_d = tick_q + 64'd1;
      if (&tick_q) begin
        phase_d = '0;
      end else if (phase_q == PHASE_LAST) begin
        phase_d = '0;
      end else begin
        phase_d = phase_q + 1'b1;
      end
      if (phase_d == '0) begin
        uptime_d = uptime_q + UPTIME_STEP;
      end
    end

    if (cmd_i.fire) begin
      for (int i = 0; i < NumTimers; i++) begin
        if (active_q[i] && (tick_q >= deadline_q[i])) begin
          fire_d[i]     = 1'b1;
          deadline_d[i] = tick_q + TIME_W'(reload_q[i]);
        end
      end
    end

    if (cmd_i.apply && !err) begin
      case (op_q)
        OP_START: begin
          deadline_d[idx] = tick_q + TIME_W'(reload_q[idx]);
          active_d[idx]   = 1'b1;
        end
        OP_RESTART: begin
          deadline_d[idx] = tick_q + TIME_W'(reload_q[idx]);
        end
        OP_STOP: begin
          active_d[idx] = 1'b0;
        end
        OP_SET_RATE: begin
          reload_d[idx] = quotient;
        end
        OP_CLEAR_ALL: begin
          active_d = '0;
          tick_d   = '0;
          uptime_d = '0;
          phase_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign fire_pad   = PadW'(fire_q);
  assign active_pad = PadW'(active_q);

  always_comb begin
    pop = '0;
    for (int i = 0; i < NumTimers; i++) begin
      pop = pop + PopW'(active_q[i]);
    end
    count_sat = (pop > PopW'(COUNT_SAT)) ? COUNT_SAT : pop[CNT_W-1:0];
  end

  assign sel_reload = id_ok ? reload_q[idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= FREQ_RESET;
      tick_q      <= '0;
      uptime_q    <= '0;
      phase_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        deadline_q[i] <= '0;
        reload_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        freq_q <= cfg_data_i;
      end
      tick_q     <= tick_d;
      uptime_q   <= uptime_d;
      phase_q    <= phase_d;
      active_q   <= active_d;
      deadline_q <= deadline_d;
      reload_q   <= reload_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fire_q <= fire_d;
    if (cmd_i.latch) begin
      op_q   <= op_e'(opcode_i);
      id_q   <= timer_id_i;
      rate_q <= rate_hz_i;
    end
    if (cmd_i.emit) begin
      fire_mask_q       <= fire_pad[MASK_W-1:0];
      tick_count_q      <= tick_q;
      uptime_ms_q       <= uptime_q;
      active_mask_q     <= active_pad[MASK_W-1:0];
      active_count_q    <= count_sat;
      selected_reload_q <= sel_reload;
      request_error_q   <= err;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign fire_mask_o       = fire_mask_q;
  assign tick_count_o      = tick_count_q;
  assign uptime_ms_o       = uptime_ms_q;
  assign active_mask_o     = active_mask_q;
  assign active_count_o    = active_count_q;
  assign selected_reload_o = selected_reload_q;
  assign request_error_o   = request_error_q;

endmodule

// ===== rtl/ptb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptb_ctrl
// Controller: sequences one beat through execute, fire or divide, and
// result hand-off.
// ----------------------------------------------------------------------------
module ptb_ctrl import ptb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_tick) begin
          cmd_o.inc_tick = 1'b1;
          state_d        = ST_FIRE;
        end else if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_FIRE: begin
        cmd_o.fire = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== verif/periodic_timer_bank_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_tb
// Drives ticks and channel commands into the timer bank and checks every
// status beat, field by field, against a predictor of the bank state kept
// here. A directed opening covers bad channels, zero rates, unused opcodes,
// clear all and a zero base frequency; random traffic follows under several
// base frequencies and stall patterns.
// ----------------------------------------------------------------------------
module periodic_timer_bank_tb;
  import ptb_pkg::*;

  localparam int unsigned        NCH            = NUM_TIMERS_DEF;
  localparam logic [OP_W-1:0]    OP_SPARE_LO    = 3'd6;
  localparam logic [OP_W-1:0]    OP_SPARE_HI    = 3'd7;
  localparam logic [TIME_W-1:0]  TICKS_PER_STEP = 64'd1000;
  localparam int unsigned        DRAIN_CYCLES   = 64;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] rate;
  } timer_cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] fire;
    logic [TIME_W-1:0] ticks;
    logic [TIME_W-1:0] uptime;
    logic [MASK_W-1:0] active;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] reload;
    logic              err;
  } bank_status_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  timer_cmd_t        in_cmd    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] fire_mask;
  logic [TIME_W-1:0] tick_count;
  logic [TIME_W-1:0] uptime_ms;
  logic [MASK_W-1:0] active_mask;
  logic [CNT_W-1:0]  active_count;
  logic [DATA_W-1:0] selected_reload;
  logic              request_error;

  logic [DATA_W-1:0] bank_freq = FREQ_RESET;
  logic [TIME_W-1:0] bank_ticks = '0;
  logic [TIME_W-1:0] bank_uptime = '0;
  logic              bank_active [NCH] = '{default: 1'b0};
  logic [TIME_W-1:0] bank_deadline [NCH] = '{default: '0};
  logic [DATA_W-1:0] bank_reload [NCH] = '{default: '0};

  timer_cmd_t   cmd_queue[$];
  bank_status_t expected_status[$];
  int unsigned  n_issued = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_errors = 0;
  int unsigned  send_idle_pct = 18;
  int unsigned  recv_idle_pct = 77;

  periodic_timer_bank dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (in_cmd.op),
    .timer_id_i       (in_cmd.id),
    .rate_hz_i        (in_cmd.rate),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .fire_mask_o      (fire_mask),
    .tick_count_o     (tick_count),
    .uptime_ms_o      (uptime_ms),
    .active_mask_o    (active_mask),
    .active_count_o   (active_count),
    .selected_reload_o(selected_reload),
    .request_error_o  (request_error)
  );

  always #6 clk_i = ~clk_i;

  function automatic bank_status_t advance_bank(input timer_cmd_t c);
    bank_status_t s;
    logic         id_ok;
    int           i;
    s = '0;
    id_ok = (c.id < NCH);
    case (c.op)
      OP_TICK: begin
        bank_ticks = bank_ticks + 64'd1;
        if (bank_ticks % TICKS_PER_STEP == 0) bank_uptime = bank_uptime + UPTIME_STEP;
        for (i = 0; i < NCH; i++) begin
          if (bank_active[i] && bank_ticks >= bank_deadline[i]) begin
            if (i < MASK_W) s.fire[i] = 1'b1;
            bank_deadline[i] = bank_ticks + {32'd0, bank_reload[i]};
          end
        end
      end
      OP_START, OP_RESTART: begin
        if (!id_ok) begin
          s.err = 1'b1;
        end else begin
          bank_deadline[c.id] = bank_ticks + {32'd0, bank_reload[c.id]};
          if (c.op == OP_START) bank_active[c.id] = 1'b1;
        end
      end
      OP_STOP: begin
        if (!id_ok) s.err = 1'b1;
        else bank_active[c.id] = 1'b0;
      end
      OP_SET_RATE: begin
        if (!id_ok || c.rate == 0) s.err = 1'b1;
        else bank_reload[c.id] = bank_freq / c.rate;
      end
      OP_CLEAR_ALL: begin
        for (i = 0; i < NCH; i++) bank_active[i] = 1'b0;
        bank_ticks = '0;
        bank_uptime = '0;
      end
      default: begin
      end
    endcase
    for (i = 0; i < NCH; i++) begin
      if (bank_active[i]) begin
        if (i < MASK_W) s.active[i] = 1'b1;
        if (s.count < COUNT_SAT) s.count = s.count + 1'b1;
      end
    end
    s.ticks = bank_ticks;
    s.uptime = bank_uptime;
    s.reload = id_ok ? bank_reload[c.id] : '0;
    return s;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns %s: got %0h want %0h", $realtime, field, got, want);
    n_errors++;
  endtask

  task automatic check_status();
    bank_status_t want;
    if (expected_status.size() == 0) begin
      report_mismatch("status beat with no prediction", 64'(tick_count), 64'd0);
    end else begin
      want = expected_status.pop_front();
      if (fire_mask !== want.fire) report_mismatch("fire_mask", fire_mask, want.fire);
      if (tick_count !== want.ticks) report_mismatch("tick_count", tick_count, want.ticks);
      if (uptime_ms !== want.uptime) report_mismatch("uptime_ms", uptime_ms, want.uptime);
      if (active_mask !== want.active)
        report_mismatch("active_mask", active_mask, want.active);
      if (active_count !== want.count)
        report_mismatch("active_count", active_count, want.count);
      if (selected_reload !== want.reload)
        report_mismatch("selected_reload", selected_reload, want.reload);
      if (request_error !== want.err)
        report_mismatch("request_error", request_error, want.err);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_status.push_back(advance_bank(in_cmd));
        n_accepted++;
      end
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_cmd   <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_status();
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_beat(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [DATA_W-1:0] rate);
    timer_cmd_t c;
    c.op = op;
    c.id = id;
    c.rate = rate;
    cmd_queue.push_back(c);
    n_issued++;
  endtask

  task automatic queue_random(input int count);
    int                pick;
    int                rate_pick;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] rate;
    repeat (count) begin
      pick = $urandom_range(99);
      id = ($urandom_range(99) < 85) ? ID_W'($urandom_range(NCH - 1)) : ID_W'($urandom);
      rate = $urandom;
      if (pick < 50) begin
        queue_beat(OP_TICK, id, rate);
      end else if (pick < 62) begin
        queue_beat(OP_START, id, rate);
      end else if (pick < 70) begin
        queue_beat(OP_STOP, id, rate);
      end else if (pick < 78) begin
        queue_beat(OP_RESTART, id, rate);
      end else if (pick < 92) begin
        rate_pick = $urandom_range(99);
        if (rate_pick < 70) begin
          rate = bank_freq / $urandom_range(1, 24);
          if (rate == 0) rate = 1;
        end else if (rate_pick < 78) begin
          rate = '0;
        end else if (rate_pick < 88) begin
          rate = $urandom_range(1, 16);
        end
        queue_beat(OP_SET_RATE, id, rate);
      end else if (pick < 95) begin
        queue_beat(OP_CLEAR_ALL, id, rate);
      end else if (pick < 97) begin
        queue_beat($urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO, id, rate);
      end else begin
        queue_beat(OP_W'($urandom), ID_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_issued || expected_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_freq(input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bank_freq = value;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_beat(OP_TICK, 8'd0, 32'd0);
    queue_beat(OP_SET_RATE, 8'd0, 32'd100000000);
    queue_beat(OP_SET_RATE, 8'd7, 32'hFFFF_FFFF);
    queue_beat(OP_SET_RATE, 8'd3, 32'd0);
    queue_beat(OP_SET_RATE, 8'd8, 32'd5);
    queue_beat(OP_SET_RATE, 8'd255, 32'd1);
    queue_beat(OP_START, 8'd0, 32'd0);
    queue_beat(OP_START, 8'd7, 32'hFFFF_FFFF);
    queue_beat(OP_START, 8'd255, 32'd0);
    queue_beat(OP_TICK, 8'd0, 32'd0);
    queue_beat(OP_TICK, 8'd7, 32'd0);
    queue_beat(OP_RESTART, 8'd0, 32'd0);
    queue_beat(OP_STOP, 8'd7, 32'd0);
    queue_beat(OP_STOP, 8'd200, 32'd0);
    queue_beat(OP_RESTART, 8'd8, 32'd0);
    queue_beat(OP_TICK, 8'd0, 32'd0);
    queue_beat(OP_SPARE_LO, 8'd0, 32'd0);
    queue_beat(OP_SPARE_HI, 8'd3, 32'hFFFF_FFFF);
    queue_beat(OP_SET_RATE, 8'd5, 32'd1);
    queue_beat(OP_START, 8'd5, 32'd0);
    queue_beat(OP_CLEAR_ALL, 8'd0, 32'd0);
    queue_beat(OP_TICK, 8'd5, 32'd0);
    wait_idle();

    write_freq('0);
    queue_beat(OP_SET_RATE, 8'd1, 32'd7);
    queue_beat(OP_START, 8'd1, 32'd0);
    queue_beat(OP_TICK, 8'd1, 32'd0);
    wait_idle();

    write_freq('1);
    queue_random(180);
    wait_idle();

    send_idle_pct = 77;
    recv_idle_pct = 18;
    write_freq(32'd1);
    queue_random(180);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_freq($urandom_range(1000, 32'hFFFF_FFFE));
    queue_random(220);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("periodic_timer_bank_tb: done, clean");
    end else begin
      $display("periodic_timer_bank_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("periodic_timer_bank_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptb_pkg.sv
rtl/ptb_div.sv
rtl/ptb_dp.sv
rtl/ptb_ctrl.sv
rtl/periodic_timer_bank.sv
verif/periodic_timer_bank_tb.sv
